/* design/prwec_pkg.sv */
// Package for the per-requester windowed event counter.
// Types, sizes and reset constants; no dependencies.
package prwec_pkg;

    localparam int MaxProcesses = 10;
    localparam int MaxWindows   = 12;
    localparam logic [15:0] WindowSecondsReset = 16'd300;

    localparam logic CmdReport = 1'b0;
    localparam logic CmdRead   = 1'b1;

    typedef struct packed {
        logic        command;
        logic [30:0] pid;
        logic [31:0] now_seconds;
        logic        is_null_event;
        logic [3:0]  read_process_rank;
        logic [3:0]  read_window_rank;
    } t_in_beat;

    typedef struct packed {
        logic        entry_valid;
        logic        found_existing;
        logic        opened_window;
        logic        evicted_process;
        logic [30:0] pid_out;
        logic [31:0] window_start;
        logic [31:0] null_count;
        logic [31:0] hid_count;
        logic [3:0]  windows_held;
    } t_out_beat;

endpackage

/* design/per_requester_windowed_event_counter.sv */
// Top level of the per-requester windowed event counter.
// Depends on prwec_pkg.
// Busy on a read while the ring slot is picked and the window fetched; on a report for
// the slot scan, one slot a cycle on the shared compare, the window fetch, then an
// update or a window opening through a 32-step restoring division.
// The result strobe is raised in the same cycle that busy drops; one item at a time.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset clears the slot table control, fill counts and window length to 300.
module per_requester_windowed_event_counter #(
    parameter int P_PROCS = prwec_pkg::MaxProcesses,
    parameter int P_WINS  = prwec_pkg::MaxWindows
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  prwec_pkg::t_in_beat  i_in,
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_data,
    output logic                 o_res_strobe,
    output prwec_pkg::t_out_beat o_res
);
    import prwec_pkg::*;

    localparam int PW = (P_PROCS > 1) ? $clog2(P_PROCS) : 1;
    localparam int WW = (P_WINS > 1) ? $clog2(P_WINS) : 1;
    localparam int MW = $clog2(P_PROCS * P_WINS);
    localparam int MD = P_PROCS * P_WINS;

    localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_ALLOC = 4'd2,
        S_RDA = 4'd3, S_RDB = 4'd4, S_CHK = 4'd5, S_DIV = 4'd6,
        S_OPEN = 4'd7, S_WR = 4'd8, S_RRD = 4'd9, S_ROUT = 4'd10;

    logic [3:0]  r_state;
    logic [15:0] r_wsec;
    t_in_beat    r_in;
    logic [30:0] r_slot_pid [P_PROCS];
    logic [P_PROCS-1:0] r_used;
    logic [PW-1:0] r_oldest;
    logic [PW:0]   r_inuse;
    logic [WW-1:0] r_newest [P_PROCS];
    logic [WW:0]   r_fill [P_PROCS];
    logic [31:0] r_mb [MD];
    logic [31:0] r_mn [MD];
    logic [31:0] r_mr [MD];
    logic [31:0] r_qb, r_qn, r_qr;
    logic [PW:0]   r_idx;
    logic [PW-1:0] r_s;
    logic [WW-1:0] r_w;
    logic r_found, r_evict, r_open;
    logic [31:0] r_rem;
    logic [16:0] r_dvr;
    logic [5:0]  r_cnt;
    logic [31:0] r_begin, r_nc, r_rc;
    logic r_we;

    logic [15:0] w_len;
    logic [MW-1:0] w_addr;
    logic [PW-1:0] w_ring;
    logic [WW:0]   w_wsum;
    logic [16:0]   w_trial;
    logic [32:0]   w_end;

    assign w_len = (r_wsec == 16'd0) ? 16'd1 : r_wsec;
    assign w_addr = MW'(r_s) * MW'(P_WINS) + MW'(r_w);
    assign w_end = {1'b0, r_qb} + 33'(w_len);
    assign w_trial = {r_dvr[15:0], r_rem[31]} - {1'b0, w_len};

    always_comb begin
        logic [PW+4:0] t;
        t = (PW+5)'(r_oldest) + (PW+5)'(r_in.read_process_rank);
        if (t >= (PW+5)'(P_PROCS)) t = t - (PW+5)'(P_PROCS);
        w_ring = PW'(t);
        w_wsum = (WW+1)'(r_newest[r_s]) + (WW+1)'(P_WINS)
               - (WW+1)'(r_in.read_window_rank);
    end

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            r_mb[w_addr] <= r_begin;
            r_mn[w_addr] <= r_nc;
            r_mr[w_addr] <= r_rc;
        end
        r_qb <= r_mb[w_addr];
        r_qn <= r_mn[w_addr];
        r_qr <= r_mr[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wsec <= WindowSecondsReset;
            r_used <= '0;
            r_oldest <= '0;
            r_inuse <= '0;
            r_we <= 1'b0;
            o_res_strobe <= 1'b0;
            for (int k = 0; k < P_PROCS; k++) begin
                r_newest[k] <= '0;
                r_fill[k] <= '0;
            end
        end else begin
            r_we <= (r_state == S_WR);
            o_res_strobe <= (r_state == S_WR) || (r_state == S_ROUT && r_cnt > 6'd1);
            if (i_cfg_we) r_wsec <= i_cfg_data;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_in <= i_in;
                        r_idx <= '0;
                        r_found <= 1'b0;
                        r_evict <= 1'b0;
                        r_open <= 1'b0;
                        r_state <= (i_in.command == CmdRead) ? S_RRD : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_idx == (PW+1)'(P_PROCS)) begin
                        r_state <= S_ALLOC;
                    end else if (r_used[PW'(r_idx)] &&
                                 r_slot_pid[PW'(r_idx)] == r_in.pid) begin
                        r_s <= PW'(r_idx);
                        r_found <= 1'b1;
                        r_state <= S_RDA;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_ALLOC: begin
                    logic [PW+1:0] t;
                    logic [PW-1:0] s;
                    if (r_inuse < (PW+1)'(P_PROCS)) begin
                        t = (PW+2)'(r_oldest) + (PW+2)'(r_inuse);
                        if (t >= (PW+2)'(P_PROCS)) t = t - (PW+2)'(P_PROCS);
                        s = PW'(t);
                        r_inuse <= r_inuse + 1'b1;
                    end else begin
                        s = r_oldest;
                        r_oldest <= (r_oldest == PW'(P_PROCS-1)) ? '0 : r_oldest + 1'b1;
                        r_evict <= 1'b1;
                    end
                    r_s <= s;
                    r_used[s] <= 1'b1;
                    r_slot_pid[s] <= r_in.pid;
                    r_fill[s] <= '0;
                    r_newest[s] <= '0;
                    r_state <= S_RDA;
                end
                S_RDA: begin
                    r_w <= r_newest[r_s];
                    r_state <= S_RDB;
                end
                S_RDB: r_state <= S_CHK;
                S_CHK: begin
                    if (r_fill[r_s] != '0 && {1'b0, r_in.now_seconds} < w_end) begin
                        r_begin <= r_qb;
                        r_nc <= (r_in.is_null_event && r_qn != '1) ? r_qn + 1'b1 : r_qn;
                        r_rc <= (!r_in.is_null_event && r_qr != '1) ? r_qr + 1'b1 : r_qr;
                        r_state <= S_WR;
                    end else begin
                        r_open <= 1'b1;
                        r_rem <= r_in.now_seconds;
                        r_dvr <= '0;
                        r_cnt <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // remainder only: shift dividend through r_dvr
                    if (!w_trial[16]) r_dvr <= w_trial;
                    else r_dvr <= {r_dvr[15:0], r_rem[31]};
                    r_rem <= {r_rem[30:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 6'd31) r_state <= S_OPEN;
                end
                S_OPEN: begin
                    r_begin <= r_in.now_seconds - 32'(r_dvr[15:0]);
                    r_nc <= {31'd0, r_in.is_null_event};
                    r_rc <= {31'd0, !r_in.is_null_event};
                    if (r_fill[r_s] != '0)
                        r_w <= (r_w == WW'(P_WINS-1)) ? '0 : r_w + 1'b1;
                    else
                        r_w <= '0;
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (r_open) begin
                        r_newest[r_s] <= r_w;
                        if (r_fill[r_s] < (WW+1)'(P_WINS)) r_fill[r_s] <= r_fill[r_s] + 1'b1;
                    end
                    o_res.entry_valid <= 1'b1;
                    o_res.found_existing <= r_found;
                    o_res.opened_window <= r_open;
                    o_res.evicted_process <= r_evict;
                    o_res.pid_out <= r_slot_pid[r_s];
                    o_res.window_start <= r_begin;
                    o_res.null_count <= r_nc;
                    o_res.hid_count <= r_rc;
                    o_res.windows_held <= 4'(r_fill[r_s] +
                        ((r_open && r_fill[r_s] < (WW+1)'(P_WINS)) ? 1'b1 : 1'b0));
                    r_state <= S_IDLE;
                end
                S_RRD: begin
                    r_s <= w_ring;
                    r_state <= S_ROUT;
                end
                S_ROUT: begin
                    t_out_beat v;
                    v = '0;
                    if ({1'b0, r_in.read_process_rank} < 5'(r_inuse)) begin
                        v.pid_out = r_slot_pid[r_s];
                        v.windows_held = 4'(r_fill[r_s]);
                        if ({1'b0, r_in.read_window_rank} < 5'(r_fill[r_s])) begin
                            v.entry_valid = 1'b1;
                            v.window_start = r_qb;
                            v.null_count = r_qn;
                            v.hid_count = r_qr;
                        end
                    end
                    if (r_cnt == 6'd0) begin
                        r_w <= (w_wsum >= (WW+1)'(P_WINS)) ? WW'(w_wsum - (WW+1)'(P_WINS))
                                                          : WW'(w_wsum);
                        r_cnt <= 6'd1;
                    end else if (r_cnt == 6'd1) begin
                        r_cnt <= 6'd2;
                    end else begin
                        r_cnt <= 6'd0;
                        o_res <= v;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_IDLE && start) r_cnt <= '0;
        end
    end

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> !busy) else $error("result while busy");
    a_inuse_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inuse <= (PW+1)'(P_PROCS)) else $error("slot count overflow");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accepted item not taken");

endmodule

/* test/prwec_checker.sv */
// Checker for the per-requester windowed event counter: watches accepted beats,
// predicts results with its own model of the slot and window tables.
// Depends on prwec_pkg.
`timescale 1ns / 1ps
module prwec_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  prwec_pkg::t_in_beat  i_in,
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_res_strobe,
    input  prwec_pkg::t_out_beat i_res,
    output int                   o_errors,
    output int                   o_pending
);
    import prwec_pkg::*;

    logic [15:0] win_len;
    logic [30:0] tab_pid [MaxProcesses];
    logic        tab_used [MaxProcesses];
    int          head_slot;
    int          n_slots;
    logic [31:0] w_begin [MaxProcesses][MaxWindows];
    logic [31:0] w_null [MaxProcesses][MaxWindows];
    logic [31:0] w_real [MaxProcesses][MaxWindows];
    int          w_newest [MaxProcesses];
    int          w_fill [MaxProcesses];
    t_out_beat   expected_q [$];

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    task automatic fill_window(inout t_out_beat r, input int s, input int w);
        r.pid_out      = tab_pid[s];
        r.window_start = w_begin[s][w];
        r.null_count   = w_null[s][w];
        r.hid_count    = w_real[s][w];
        r.windows_held = w_fill[s][3:0];
    endtask

    task automatic count_event(input t_in_beat b, output t_out_beat r);
        int s;
        int w;
        logic [31:0] len;
        logic [32:0] w_end;
        r = '0;
        len = (win_len == 0) ? 32'd1 : {16'd0, win_len};
        if (b.command == CmdRead) begin
            if (b.read_process_rank >= n_slots) return;
            s = (head_slot + b.read_process_rank) % MaxProcesses;
            r.pid_out = tab_pid[s];
            r.windows_held = w_fill[s][3:0];
            if (b.read_window_rank >= w_fill[s]) return;
            w = (w_newest[s] + MaxWindows - (b.read_window_rank % MaxWindows)) % MaxWindows;
            r.entry_valid = 1'b1;
            fill_window(r, s, w);
            return;
        end
        s = -1;
        for (int i = 0; i < MaxProcesses; i++)
            if (s < 0 && tab_used[i] && tab_pid[i] == b.pid) s = i;
        r.found_existing = (s >= 0);
        if (s < 0) begin
            if (n_slots < MaxProcesses) begin
                s = (head_slot + n_slots) % MaxProcesses;
                n_slots++;
            end else begin
                s = head_slot;
                head_slot = (head_slot + 1) % MaxProcesses;
                r.evicted_process = 1'b1;
            end
            tab_used[s] = 1'b1;
            tab_pid[s] = b.pid;
            w_fill[s] = 0;
            w_newest[s] = 0;
        end
        w = w_newest[s];
        w_end = {1'b0, w_begin[s][w]} + {1'b0, len};
        if (w_fill[s] > 0 && {1'b0, b.now_seconds} < w_end) begin
            if (b.is_null_event) w_null[s][w] = sat_inc(w_null[s][w]);
            else w_real[s][w] = sat_inc(w_real[s][w]);
        end else begin
            r.opened_window = 1'b1;
            w = (w_fill[s] > 0) ? (w + 1) % MaxWindows : 0;
            w_newest[s] = w;
            if (w_fill[s] < MaxWindows) w_fill[s]++;
            w_begin[s][w] = b.now_seconds - (b.now_seconds % len);
            w_null[s][w] = b.is_null_event ? 32'd1 : 32'd0;
            w_real[s][w] = b.is_null_event ? 32'd0 : 32'd1;
        end
        r.entry_valid = 1'b1;
        fill_window(r, s, w);
    endtask

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_out_beat e;
        if (!i_rst_n) begin
            o_errors = 0;
            win_len = WindowSecondsReset;
            head_slot = 0;
            n_slots = 0;
            for (int i = 0; i < MaxProcesses; i++) begin
                tab_used[i] = 1'b0;
                w_newest[i] = 0;
                w_fill[i] = 0;
            end
            expected_q.delete();
        end else begin
            if (i_res_strobe) begin
                if (expected_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) $display("unexpected result beat %p", i_res);
                end else begin
                    e = expected_q.pop_front();
                    if (e !== i_res) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("mismatch: expected %p, got %p", e, i_res);
                    end
                end
            end
            if (i_cfg_we) win_len = i_cfg_data;
            if (i_start && !i_busy) begin
                count_event(i_in, e);
                expected_q.push_back(e);
            end
        end
    end

endmodule

/* test/per_requester_windowed_event_counter_tb.sv */
// Testbench top: drives report and read beats and window length settings.
// Depends on prwec_pkg, the block and prwec_checker.
`timescale 1ns / 1ps
module per_requester_windowed_event_counter_tb;
    import prwec_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    t_in_beat   in_beat = '0;
    logic       cfg_we = 1'b0;
    logic [15:0] cfg_data = '0;
    logic       res_strobe;
    t_out_beat  res;
    int         errors;
    int         pending;
    int         gap_pct;
    longint     cycles = 0;
    logic [30:0] pid_pool [16];
    logic [31:0] clock_now;

    per_requester_windowed_event_counter u_top (
        .i_clk(clk), .i_rst_n(rst_n), .start(start), .busy(busy), .i_in(in_beat),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data), .o_res_strobe(res_strobe), .o_res(res)
    );

    prwec_checker u_chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_busy(busy), .i_in(in_beat),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data), .i_res_strobe(res_strobe), .i_res(res),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 1000000) begin
            $display("** per_requester_windowed_event_counter: FAILED **");
            $finish;
        end
    end

    task automatic send(input t_in_beat b);
        while ($urandom_range(99) < gap_pct) @(posedge clk);
        start <= 1'b1;
        in_beat <= b;
        @(posedge clk);
        while (busy) @(posedge clk);
        start <= 1'b0;
        @(posedge clk);
    endtask

    task automatic report(input logic [30:0] p, input logic [31:0] t, input logic nul);
        t_in_beat b;
        b = '0;
        b.command = CmdReport;
        b.pid = p;
        b.now_seconds = t;
        b.is_null_event = nul;
        b.read_process_rank = 4'($urandom);
        b.read_window_rank = 4'($urandom);
        send(b);
    endtask

    task automatic read_win(input logic [3:0] pr, input logic [3:0] wr);
        t_in_beat b;
        b = '0;
        b.command = CmdRead;
        b.pid = 31'($urandom);
        b.now_seconds = $urandom;
        b.is_null_event = 1'($urandom);
        b.read_process_rank = pr;
        b.read_window_rank = wr;
        send(b);
    endtask

    task automatic set_window(input logic [15:0] v);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 55) begin
                clock_now = clock_now + $urandom_range(0, 2 * 400);
                report(pid_pool[$urandom_range(15)], clock_now, 1'($urandom));
            end else if (k < 60) begin
                report(31'($urandom), $urandom, 1'($urandom));
            end else if (k < 65) begin
                report(pid_pool[$urandom_range(15)], clock_now - $urandom_range(500),
                       1'($urandom));
            end else if (k < 90) begin
                read_win(4'($urandom_range(10)), 4'($urandom_range(12)));
            end else begin
                read_win(4'($urandom), 4'($urandom));
            end
        end
    endtask

    initial begin
        logic [15:0] lens [5];
        gap_pct = 30;
        for (int i = 0; i < 16; i++) pid_pool[i] = 31'($urandom);
        clock_now = $urandom;
        lens = '{16'd0, 16'd1, 16'hFFFF, 16'd7, 16'd300};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        read_win(4'd0, 4'd0);
        report(31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        report(31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        report(31'h0, 32'h0, 1'b0);
        report(31'h0, 32'd299, 1'b1);
        report(31'h0, 32'd300, 1'b0);
        report(31'h0, 32'd10, 1'b0);
        for (int i = 1; i <= 10; i++) report(31'(i), 32'(i * 1000), i[0]);
        read_win(4'd9, 4'd0);
        read_win(4'd0, 4'd11);
        read_win(4'd15, 4'd15);
        read_win(4'd3, 4'd0);
        for (int i = 0; i < 13; i++) report(31'd5, 32'(i * 400), 1'b0);
        read_win(4'd4, 4'd11);
        read_win(4'd4, 4'd12);

        for (int ph = 0; ph < 5; ph++) begin
            set_window(lens[ph]);
            gap_pct = (ph % 3 == 0) ? 30 : (ph % 3 == 1) ? 80 : 0;
            random_phase(400);
        end

        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0) begin
            $display("** per_requester_windowed_event_counter: PASSED **");
        end else begin
            $display("** per_requester_windowed_event_counter: FAILED **");
        end
        $finish;
    end
endmodule

/* sim.f */
design/prwec_pkg.sv
design/per_requester_windowed_event_counter.sv
test/prwec_checker.sv
test/per_requester_windowed_event_counter_tb.sv
